// ===== src/p25519_field_alu_macros.svh =====
// assertion helpers for the field alu
`ifndef P25519_FIELD_ALU_MACROS_SVH
`define P25519_FIELD_ALU_MACROS_SVH

// same-cycle implication, quiet during reset
`define P25519_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define P25519_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/p25519_pkg.sv =====
`timescale 1ns / 1ps

package p25519_pkg;

    localparam int DigitW = 32;
    localparam int WordW  = 256;
    localparam int AccW   = 257;
    localparam int TopW   = 8;

    // operation codes
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;

    // 2^256 is congruent to this modulo 2^255-19
    localparam logic signed [15:0] FOLD_K = 16'sd38;

    // data moving down the multiplier chain
    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic [WordW-1:0]   a;
        logic [WordW-1:0]   b;
        logic [AccW-1:0]    acc;
        logic [WordW-1:0]   lo;
    } t_mul_bus;

    // value as low word plus a small signed multiple of 2^256
    typedef struct packed {
        logic                   valid;
        logic [WordW-1:0]       low;
        logic signed [TopW-1:0] top;
    } t_fold_bus;

endpackage

// ===== src/p25519_mul_cell.sv =====
`timescale 1ns / 1ps

module p25519_mul_cell
    import p25519_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_mul_bus i_bus,
    output t_mul_bus o_bus
);

    t_mul_bus           r_s1, r_s2, n_s1, n_s2;
    logic [63:0]        r_pp [8];
    logic [63:0]        n_pp [8];
    logic [DigitW-1:0]  w_ad;
    logic [WordW-1:0]   w_ev;
    logic [WordW-1:0]   w_od;
    logic [288:0]       w_t;

    // first half: low digit of a times every digit of b
    // a is rotated so that it leaves the chain whole for add and subtract
    always_comb begin
        w_ad = i_bus.a[DigitW-1:0];
        for (int j = 0; j < 8; j++) begin
            n_pp[j] = 64'(w_ad) * 64'(i_bus.b[DigitW*j +: DigitW]);
        end
        n_s1   = i_bus;
        n_s1.a = {i_bus.a[DigitW-1:0], i_bus.a[WordW-1:DigitW]};
    end

    // second half: add the row into the running sum, retire one digit
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_ev[64*j +: 64] = r_pp[2*j];
            w_od[64*j +: 64] = r_pp[2*j+1];
        end
        w_t = 289'(r_s1.acc) + 289'(w_ev) + {1'b0, w_od, {DigitW{1'b0}}};
        n_s2     = r_s1;
        n_s2.acc = w_t[288:DigitW];
        n_s2.lo  = {w_t[DigitW-1:0], r_s1.lo[WordW-1:DigitW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_pp <= n_pp;
            r_s2 <= n_s2;
        end
    end

    assign o_bus = r_s2;

endmodule

// ===== src/p25519_fold_cell.sv =====
`timescale 1ns / 1ps

module p25519_fold_cell
    import p25519_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_fold_bus i_bus,
    output t_fold_bus o_bus
);

    t_fold_bus          r_bus, n_bus;
    logic signed [15:0] w_m;
    logic signed [265:0] w_s;

    // low + 38 * top, split again into low word and overflow
    always_comb begin
        w_m       = 16'(i_bus.top) * FOLD_K;
        w_s       = $signed({10'b0, i_bus.low}) + 266'(w_m);
        n_bus     = i_bus;
        n_bus.low = w_s[WordW-1:0];
        n_bus.top = w_s[WordW+TopW-1:WordW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== src/p25519_field_alu.sv =====
`timescale 1ns / 1ps
// field add, subtract and multiply modulo 2^255-19, result not fully reduced
// input channel: i_valid / o_stall with i_kind (0 add, 1 sub, 2 or 3 mul)
//   and operands a, b as four 64-bit limbs each, limb0 least significant
// output channel: o_valid / i_stall with result limbs o_r_limb0..3
// every item passes through the same stages, whatever its kind:
//   eight multiplier cells of two stages each (one 32-bit digit of a per
//   cell), one stage that folds a product's top half by 38 or forms the sum
//   or difference, and two small fold cells that absorb any carry or borrow
// one item is accepted every cycle while the output is not stalled
// the pipeline moves as one: when o_valid is high and i_stall is high,
//   everything holds and o_stall is raised until the result is taken
// reset clears all valid bits; no item is in flight afterwards

module p25519_field_alu
    import p25519_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_a_limb0,
    input  logic [63:0] i_a_limb1,
    input  logic [63:0] i_a_limb2,
    input  logic [63:0] i_a_limb3,
    input  logic [63:0] i_b_limb0,
    input  logic [63:0] i_b_limb1,
    input  logic [63:0] i_b_limb2,
    input  logic [63:0] i_b_limb3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_r_limb0,
    output logic [63:0] o_r_limb1,
    output logic [63:0] o_r_limb2,
    output logic [63:0] o_r_limb3
);

    t_mul_bus          w_mbus [9];
    t_fold_bus         w_fbus [3];
    t_fold_bus         r_ent, n_ent;
    logic              w_en;
    logic [WordW-1:0]  w_hi;
    logic [261:0]      w_x38;
    logic [262:0]      w_msum;
    logic [256:0]      w_as;

    // whole pipeline advances unless a finished result is held
    assign w_en    = !(w_fbus[2].valid && i_stall);
    assign o_stall = !w_en;

    // chain entry
    always_comb begin
        w_mbus[0].valid = i_valid;
        w_mbus[0].kind  = i_kind;
        w_mbus[0].a     = {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0};
        w_mbus[0].b     = {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0};
        w_mbus[0].acc   = '0;
        w_mbus[0].lo    = '0;
    end

    // multiplier cells, one digit of a each
    for (genvar k = 0; k < 8; k++) begin : g_mul
        p25519_mul_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bus   (w_mbus[k]),
            .o_bus   (w_mbus[k+1])
        );
    end

    // first fold: low + 38 * high for multiply, plain add/sub otherwise
    always_comb begin
        w_hi   = w_mbus[8].acc[WordW-1:0];
        w_x38  = {1'b0, w_hi, 5'b0} + {4'b0, w_hi, 2'b0} + {5'b0, w_hi, 1'b0};
        w_msum = 263'(w_x38) + 263'(w_mbus[8].lo);
        if (w_mbus[8].kind == KIND_SUB) begin
            w_as = {1'b0, w_mbus[8].a} - {1'b0, w_mbus[8].b};
        end else begin
            w_as = {1'b0, w_mbus[8].a} + {1'b0, w_mbus[8].b};
        end
        n_ent.valid = w_mbus[8].valid;
        if (w_mbus[8].kind[1]) begin
            n_ent.low = w_msum[WordW-1:0];
            n_ent.top = {1'b0, w_msum[262:WordW]};
        end else if (w_mbus[8].kind == KIND_SUB) begin
            n_ent.low = w_as[WordW-1:0];
            n_ent.top = {TopW{w_as[WordW]}};
        end else begin
            n_ent.low = w_as[WordW-1:0];
            n_ent.top = {{(TopW-1){1'b0}}, w_as[WordW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (w_en) begin
            r_ent <= n_ent;
        end
    end

    assign w_fbus[0] = r_ent;

    // remaining carry or borrow is folded away in two cells
    for (genvar k = 0; k < 2; k++) begin : g_fold
        p25519_fold_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bus   (w_fbus[k]),
            .o_bus   (w_fbus[k+1])
        );
    end

    // result
    assign o_valid   = w_fbus[2].valid;
    assign o_r_limb0 = w_fbus[2].low[63:0];
    assign o_r_limb1 = w_fbus[2].low[127:64];
    assign o_r_limb2 = w_fbus[2].low[191:128];
    assign o_r_limb3 = w_fbus[2].low[255:192];

endmodule

// ===== src/p25519_field_alu_checker.sv =====
`timescale 1ns / 1ps
`include "p25519_field_alu_macros.svh"

module p25519_field_alu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_r_limb0,
    input logic [63:0] o_r_limb3
);

    // input only held back by a stalled result
    `P25519_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "stall without held result")

    // pipeline empty after reset
    `P25519_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_valid, "result valid after reset")

    // held result keeps its value
    `P25519_ASSERT_NEXT(a_hold, i_clk, i_rst_n && o_valid && i_stall, o_valid && $stable(o_r_limb0) && $stable(o_r_limb3), "stalled result changed")

endmodule

bind p25519_field_alu p25519_field_alu_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_r_limb0 (o_r_limb0),
    .o_r_limb3 (o_r_limb3)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import p25519_pkg::*;

    localparam int LATENCY = 19;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [255:0] ALL_ONES = {256{1'b1}};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [63:0] i_a_limb0, i_a_limb1, i_a_limb2, i_a_limb3;
    logic [63:0] i_b_limb0, i_b_limb1, i_b_limb2, i_b_limb3;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_r_limb0, o_r_limb1, o_r_limb2, o_r_limb3;

    // one row of the directed stimulus
    typedef struct {
        logic [1:0]   kind;
        logic [255:0] a;
        logic [255:0] b;
        logic         typed;
        logic [255:0] result;
    } t_row;

    t_row         rows[$];
    logic [255:0] pending_results[$];
    logic         typed_flags[$];
    logic [255:0] typed_values[$];
    int           errors;
    int           receiver_mode;

    p25519_field_alu DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // value congruent to the exact result, folded by 38 until it fits
    function automatic logic [255:0] field_result(logic [1:0] kind, logic [255:0] a,
                                                  logic [255:0] b);
        logic [511:0] wide;
        logic [256:0] diff;
        if (kind == KIND_ADD) begin
            wide = {256'b0, a} + {256'b0, b};
        end else if (kind == KIND_SUB) begin
            diff = {1'b0, a} - {1'b0, b};
            while (diff[256])
                diff = {1'b0, diff[255:0]} - 257'd38;
            return diff[255:0];
        end else begin
            wide = {256'b0, a} * {256'b0, b};
        end
        while (wide[511:256] != 256'b0)
            wide = {256'b0, wide[255:0]} + wide[511:256] * 512'd38;
        return wide[255:0];
    endfunction

    function automatic logic [255:0] random_operand();
        logic [255:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case (sel)
            0: v = ALL_ONES;
            1: v = 256'b0;
            2: v = ALL_ONES - 256'($urandom_range(0, 60));
            3: v = 256'($urandom_range(0, 60));
            4: v[255:192] = {64{1'b1}};
            default: ;
        endcase
        return v;
    endfunction

    // accepted items are predicted, accepted results checked
    always @(posedge i_clk) begin
        logic [255:0] expected, actual;
        if (i_rst_n && i_valid && !o_stall) begin
            expected = field_result(i_kind, {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0},
                                    {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0});
            if (typed_flags.size() != 0 && typed_flags.pop_front())
                expected = typed_values.pop_front();
            pending_results.push_back(expected);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            actual = {o_r_limb3, o_r_limb2, o_r_limb1, o_r_limb0};
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, actual);
                errors++;
            end else begin
                expected = pending_results.pop_front();
                for (int i = 0; i < 4; i++)
                    if (expected[64*i +: 64] !== actual[64*i +: 64]) begin
                        $display("%0t: limb %0d expected %h actual %h",
                                 $time, i, expected[64*i +: 64], actual[64*i +: 64]);
                        errors++;
                    end
            end
        end
    end

    // receiver stall pattern, mode changes every so often
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            receiver_mode <= $urandom_range(0, 3);
        case (receiver_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            2: i_stall <= ($urandom_range(0, 9) < 8);
            default: i_stall <= ~i_stall;
        endcase
    end

    // present one item and hold it until accepted
    task automatic send_item(logic [1:0] kind, logic [255:0] a, logic [255:0] b);
        i_valid <= 1'b1;
        i_kind  <= kind;
        {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0} <= a;
        {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0} <= b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [1:0] kind, logic [255:0] a, logic [255:0] b,
                           logic typed, logic [255:0] result);
        t_row r;
        r.kind = kind;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.result = result;
        rows.push_back(r);
    endtask

    initial begin
        int burst;
        int wait_cycles;
        logic drain;
        errors = 0;
        receiver_mode = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_ADD;
        {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0} = '0;
        {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0} = '0;

        // directed rows: extremes, every kind, repeated carry and borrow
        add_row(KIND_ADD, 256'b0, 256'b0, 1'b1, 256'b0);
        add_row(KIND_SUB, 256'b0, 256'b0, 1'b1, 256'b0);
        add_row(KIND_MUL, 256'b0, ALL_ONES, 1'b1, 256'b0);
        add_row(KIND_SUB, 256'b0, 256'd1, 1'b1, ALL_ONES - 256'd38);
        add_row(KIND_ADD, ALL_ONES, 256'd1, 1'b1, 256'd38);
        add_row(KIND_MUL, 256'd1, ALL_ONES, 1'b1, ALL_ONES);
        add_row(2'd3, 256'd1, ALL_ONES, 1'b1, ALL_ONES);
        add_row(KIND_ADD, ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(KIND_SUB, 256'b0, ALL_ONES, 1'b0, '0);
        add_row(KIND_SUB, 256'd5, 256'd40, 1'b0, '0);
        add_row(KIND_SUB, 256'd10, 256'd50, 1'b0, '0);
        add_row(KIND_MUL, ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(2'd3, ALL_ONES, ALL_ONES - 256'd7, 1'b0, '0);
        add_row(KIND_ADD, ALL_ONES - 256'd37, ALL_ONES, 1'b0, '0);
        add_row(KIND_MUL, {64'hffffffffffffffff, 192'b0}, ALL_ONES, 1'b0, '0);
        add_row(KIND_ADD, ALL_ONES, 256'b0, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, back to back, running straight into the random part
        foreach (rows[i]) begin
            typed_flags.push_back(rows[i].typed);
            if (rows[i].typed)
                typed_values.push_back(rows[i].result);
            send_item(rows[i].kind, rows[i].a, rows[i].b);
        end

        // random part in bursts with gaps
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
                typed_flags.push_back(1'b0);
                send_item(2'($urandom_range(0, 3)), random_operand(), random_operand());
            end
            drain = (n > RANDOM_ITEMS / 2 && n - burst <= RANDOM_ITEMS / 2);
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            // valid only drops where a gap, a drain or the end follows
            if (drain || wait_cycles != 0 || n >= RANDOM_ITEMS)
                i_valid <= 1'b0;
            if (drain) begin
                // drain the pipeline once mid-run
                while (pending_results.size() != 0)
                    @(negedge i_clk);
            end
            repeat (wait_cycles) @(negedge i_clk);
        end

        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
